[rtl/oslw_pkg.sv]
// Package: constants, codes and types shared by the octree leaf walker.
package oslw_pkg;
   localparam int MaxDepth  = 16;
   localparam int NodeCount = 4096;
   localparam int AddrW     = $clog2(NodeCount);
   localparam int LvlW      = $clog2(MaxDepth + 1);
   localparam int SlotW     = $clog2(MaxDepth);
   localparam int CrnAddrW  = AddrW + 3;

   typedef enum logic [1:0] {
      OP_WR_OFFSET = 2'd0,
      OP_WR_CORNER = 2'd1,
      OP_START     = 2'd2,
      OP_STEP      = 2'd3
   } op_type;

   // request from the walk sequencer to the node store
   typedef struct packed {
      logic             off_rd;
      logic [AddrW-1:0] off_addr;
      logic             crn_rd;
      logic [AddrW-1:0] crn_node;
   } mem_req_type;
endpackage

[rtl/oslw_node_store.sv]
// Node store: offset memory and corner memory with registered reads.
module oslw_node_store (
   input  logic                          clock,
   input  logic                          wr_off,
   input  logic                          wr_crn,
   input  logic [oslw_pkg::AddrW-1:0]    wr_addr,
   input  logic [2:0]                    wr_corner,
   input  logic [15:0]                   wr_word,
   input  oslw_pkg::mem_req_type         req,
   output logic [oslw_pkg::AddrW-1:0]    off_q,
   output logic [7:0]                    pat_q
);
   logic [oslw_pkg::AddrW-1:0] off_mem [oslw_pkg::NodeCount];
   // one word per node: the eight sign bits are all that reads use
   logic [7:0] sign_mem [oslw_pkg::NodeCount];

   always_ff @(posedge clock) begin
      if (wr_off) off_mem[wr_addr] <= wr_word[oslw_pkg::AddrW-1:0];
      if (req.off_rd) off_q <= off_mem[req.off_addr];
   end

   // bit-enable write of one corner sign
   always_ff @(posedge clock) begin
      if (wr_crn) sign_mem[wr_addr][wr_corner] <= wr_word[15];
      if (req.crn_rd) pat_q <= sign_mem[req.crn_node];
   end
endmodule

[rtl/octree_surface_leaf_walker.sv]
// Top level: octree depth-first walker emitting mixed-sign leaves.
//  channel | ports                | transfer
//  request | req_op .. root_size  | start high, busy low
//  result  | rsp_voxel_x .. done  | rsp_valid high, one cycle
// A write, an idle step or a pop stays idle; start visits RD1 (root offset
// and sign read); a descending step visits RD1, RD2 and FIN (parent offset
// read, child offset and sign reads, an idle hold, then stack update).
// Reset clears walk state; node memories hold nothing until written.
// The receiver cannot stall; busy is high while an item is in flight.
module octree_surface_leaf_walker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_op,
   input  logic [11:0]                     req_node_addr,
   input  logic [2:0]                      req_corner,
   input  logic signed [15:0]              req_node_word,
   input  logic signed [31:0]              req_root_x,
   input  logic signed [31:0]              req_root_y,
   input  logic signed [31:0]              req_root_z,
   input  logic [30:0]                     req_root_size,
   output logic                            rsp_valid,
   output logic signed [31:0]              rsp_voxel_x,
   output logic signed [31:0]              rsp_voxel_y,
   output logic signed [31:0]              rsp_voxel_z,
   output logic [30:0]                     rsp_voxel_edge,
   output logic [11:0]                     rsp_leaf_index,
   output logic [7:0]                      rsp_cube_pattern,
   output logic                            rsp_walk_done
);
   localparam int AW = oslw_pkg::AddrW;
   localparam int LW = oslw_pkg::LvlW;
   localparam int SW = oslw_pkg::SlotW;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_RD1 = 4'b0010, ST_RD2 = 4'b0100, ST_FIN = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic is_start_ff, is_start_in;
   logic [AW-1:0] idx_stk [oslw_pkg::MaxDepth];
   logic [31:0] x_stk [oslw_pkg::MaxDepth];
   logic [31:0] y_stk [oslw_pkg::MaxDepth];
   logic [31:0] z_stk [oslw_pkg::MaxDepth];
   logic [3:0] cur_stk [oslw_pkg::MaxDepth];
   logic [LW-1:0] lvl_ff;
   logic active_ff;
   logic [30:0] base_ff;
   logic [AW-1:0] child_ff;
   logic [3:0] cur_ff;
   logic [30:0] size_ff;
   logic [31:0] cx_ff, cy_ff, cz_ff;

   oslw_pkg::mem_req_type mreq;
   logic [AW-1:0] off_q;
   logic [7:0] pat_q;
   logic acc, wr_off, wr_crn;
   logic [SW-1:0] ls, lp;
   logic [AW-1:0] child_c;

   assign acc = start && !busy;
   assign busy = state_ff != ST_IDLE;
   assign wr_off = acc && req_op == oslw_pkg::OP_WR_OFFSET;
   assign wr_crn = acc && req_op == oslw_pkg::OP_WR_CORNER;
   assign ls = lvl_ff[SW-1:0];
   assign lp = SW'(lvl_ff - LW'(1));
   assign child_c = off_q + AW'(cur_ff);

   always_comb begin
      mreq = '0;
      if (acc && req_op == oslw_pkg::OP_START) begin
         mreq.off_rd = 1'b1; mreq.off_addr = req_node_addr[AW-1:0];
         mreq.crn_rd = 1'b1; mreq.crn_node = req_node_addr[AW-1:0];
      end else if (acc && req_op == oslw_pkg::OP_STEP) begin
         mreq.off_rd = 1'b1; mreq.off_addr = idx_stk[lp];
      end else if (state_ff == ST_RD1 && !is_start_ff) begin
         mreq.off_rd = 1'b1; mreq.off_addr = child_c;
         mreq.crn_rd = 1'b1; mreq.crn_node = child_c;
      end
   end

   oslw_node_store u_store (
      .clock(clock), .wr_off(wr_off), .wr_crn(wr_crn),
      .wr_addr(req_node_addr[AW-1:0]), .wr_corner(req_corner),
      .wr_word(req_node_word), .req(mreq), .off_q(off_q), .pat_q(pat_q)
   );

   always_comb begin
      state_in = state_ff;
      is_start_in = is_start_ff;
      case (state_ff)
         ST_IDLE: if (acc && req_op == oslw_pkg::OP_START) begin
            state_in = ST_RD1; is_start_in = 1'b1;
         end else if (acc && req_op == oslw_pkg::OP_STEP && active_ff && lvl_ff != '0
                      && lvl_ff < LW'(oslw_pkg::MaxDepth) && !cur_stk[ls][3]) begin
            state_in = ST_RD1; is_start_in = 1'b0;
         end
         ST_RD1: state_in = is_start_ff ? ST_IDLE : ST_RD2;
         ST_RD2: state_in = ST_FIN;
         ST_FIN: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         is_start_ff <= 1'b0;
         lvl_ff <= '0;
         active_ff <= 1'b0;
         base_ff <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < oslw_pkg::MaxDepth; i++) begin
            idx_stk[i] <= '0; x_stk[i] <= '0; y_stk[i] <= '0; z_stk[i] <= '0;
            cur_stk[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         is_start_ff <= is_start_in;
         rsp_valid <= 1'b0;
         rsp_walk_done <= 1'b0;
         if (acc && req_op == oslw_pkg::OP_START) begin
            base_ff <= req_root_size;
            idx_stk[0] <= req_node_addr[AW-1:0];
            x_stk[0] <= req_root_x; y_stk[0] <= req_root_y; z_stk[0] <= req_root_z;
            cur_stk[1] <= '0;
            active_ff <= 1'b1;
            lvl_ff <= LW'(1);
         end else if (acc && req_op == oslw_pkg::OP_STEP && active_ff) begin
            if (lvl_ff == '0) begin
               active_ff <= 1'b0;
               rsp_valid <= 1'b1; rsp_walk_done <= 1'b1;
               rsp_voxel_x <= '0; rsp_voxel_y <= '0; rsp_voxel_z <= '0;
               rsp_voxel_edge <= '0; rsp_leaf_index <= '0; rsp_cube_pattern <= '0;
            end else if (lvl_ff >= LW'(oslw_pkg::MaxDepth) || cur_stk[ls][3]) begin
               lvl_ff <= lvl_ff - LW'(1);
               if (lvl_ff == LW'(1)) begin
                  active_ff <= 1'b0;
                  rsp_valid <= 1'b1; rsp_walk_done <= 1'b1;
                  rsp_voxel_x <= '0; rsp_voxel_y <= '0; rsp_voxel_z <= '0;
                  rsp_voxel_edge <= '0; rsp_leaf_index <= '0; rsp_cube_pattern <= '0;
               end
            end else begin
               cur_ff <= cur_stk[ls];
               cur_stk[ls] <= cur_stk[ls] + 4'd1;
               size_ff <= base_ff >> lvl_ff;
            end
         end
         if (state_ff == ST_RD1 && is_start_ff && off_q == '0) begin
            lvl_ff <= '0;
            rsp_valid <= 1'b1;
            rsp_voxel_x <= x_stk[0]; rsp_voxel_y <= y_stk[0]; rsp_voxel_z <= z_stk[0];
            rsp_voxel_edge <= base_ff; rsp_leaf_index <= idx_stk[0];
            rsp_cube_pattern <= pat_q;
         end
         if (state_ff == ST_RD1 && !is_start_ff) begin
            child_ff <= child_c;
            cx_ff <= x_stk[lp] + (cur_ff[0] ? {1'b0, size_ff} : 32'd0);
            cy_ff <= y_stk[lp] + (cur_ff[1] ? {1'b0, size_ff} : 32'd0);
            cz_ff <= z_stk[lp] + (cur_ff[2] ? {1'b0, size_ff} : 32'd0);
         end
         if (state_ff == ST_FIN) begin
            if (off_q == '0) begin
               if (pat_q != 8'h00 && pat_q != 8'hFF) begin
                  rsp_valid <= 1'b1;
                  rsp_voxel_x <= cx_ff; rsp_voxel_y <= cy_ff; rsp_voxel_z <= cz_ff;
                  rsp_voxel_edge <= size_ff; rsp_leaf_index <= child_ff;
                  rsp_cube_pattern <= pat_q;
               end
            end else begin
               idx_stk[ls] <= child_ff;
               x_stk[ls] <= cx_ff; y_stk[ls] <= cy_ff; z_stk[ls] <= cz_ff;
               lvl_ff <= lvl_ff + LW'(1);
               if (lvl_ff + LW'(1) < LW'(oslw_pkg::MaxDepth))
                  cur_stk[SW'(lvl_ff + LW'(1))] <= '0;
            end
         end
      end
   end

   // hold read data across the idle RD2 cycle: store keeps registered output
endmodule

[rtl/oslw_checker.sv]
// Checker: port-level properties of the octree leaf walker, with bind.
module oslw_checker (
   input logic clock, input logic reset, input logic start, input logic busy,
   input logic rsp_valid, input logic rsp_walk_done,
   input logic [7:0] rsp_cube_pattern, input logic [30:0] rsp_voxel_edge
);
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_walk_done |-> rsp_cube_pattern == 8'd0 && rsp_voxel_edge == '0)
      else $error("end marker carries data");
   a_no_rsp_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid || !$past(busy))
      else $error("back to back results within one item");
   a_busy_after_reset: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");
endmodule

bind octree_surface_leaf_walker oslw_checker u_oslw_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_walk_done(rsp_walk_done),
   .rsp_cube_pattern(rsp_cube_pattern), .rsp_voxel_edge(rsp_voxel_edge)
);
